// ===== src/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// shared types and constants of the dense layer with relu
// ----------------------------------------------------------------------------
package dlr_pkg;

  // input item fields
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned ACT_W   = 15;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_W      = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INPUTS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUTPUTS = 4'd1;

  // q8.8 saturation point of the activation
  localparam logic [ACT_W-1:0] ACT_MAX = 15'h7fff;

  typedef enum logic [OP_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_INPUT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_LOAD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic w_we;
    logic b_we;
    logic x_we;
    logic issue;
    logic first;
    logic lastc;
    logic load_out;
    logic last_row;
    logic clear_x;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/dlr_ram.sv =====
// ----------------------------------------------------------------------------
// dlr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module dlr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlr_ctrl
// item decode, configuration registers and the row/column sequencer
// ----------------------------------------------------------------------------
module dlr_ctrl import dlr_pkg::*; #(
  parameter int unsigned MAX_INPUTS  = 16,
  parameter int unsigned MAX_OUTPUTS = 16,
  localparam int unsigned IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int unsigned OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IDX_W-1:0]     row_i,
  input  logic [IDX_W-1:0]     col_i,
  input  logic                 last_element_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  sts_t                 sts_i,
  output cmd_t                 cmd_o,
  output logic [OW-1:0]        r_o,
  output logic [IW-1:0]        c_o
);

  state_e           state_q, state_d;
  logic [OW-1:0]    r_q, r_d;
  logic [IW-1:0]    c_q, c_d;
  logic [CFG_W-1:0] n_in_q, n_out_q;
  logic [IW-1:0]    in_last;
  logic [OW-1:0]    out_last;
  logic             row_ok, col_ok;

  // configuration, to be written by the user only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_in_q  <= CFG_RESET;
      n_out_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_INPUTS:  n_in_q  <= cfg_data_i;
        CFG_IDX_OUTPUTS: n_out_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counts clamped to 1..store size, kept as last index
  always_comb begin
    if (n_in_q == '0) begin
      in_last = '0;
    end else if (32'(n_in_q) > MAX_INPUTS) begin
      in_last = IW'(MAX_INPUTS - 1);
    end else begin
      in_last = IW'(n_in_q - 5'd1);
    end
    if (n_out_q == '0) begin
      out_last = '0;
    end else if (32'(n_out_q) > MAX_OUTPUTS) begin
      out_last = OW'(MAX_OUTPUTS - 1);
    end else begin
      out_last = OW'(n_out_q - 5'd1);
    end
  end

  assign row_ok = 32'(row_i) < MAX_OUTPUTS;
  assign col_ok = 32'(col_i) < MAX_INPUTS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // ready is always high here, valid alone marks a transfer
        if (in_valid_i) begin
          unique case (op_i)
            OP_WEIGHT: cmd_o.w_we = row_ok && col_ok;
            OP_BIAS:   cmd_o.b_we = row_ok;
            OP_INPUT: begin
              cmd_o.x_we = col_ok;
              if (last_element_i) begin
                r_d     = '0;
                c_d     = '0;
                state_d = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (c_q == '0);
        cmd_o.lastc = (c_q == in_last);
        if (c_q == in_last) begin
          state_d = ST_WAIT;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (sts_i.acc_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.last_row = (r_q == out_last);
          if (r_q == out_last) begin
            cmd_o.clear_x = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            r_d     = r_q + 1'b1;
            c_d     = '0;
            state_d = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign r_o = r_q;
  assign c_o = c_q;

endmodule

// ===== src/dlr_datapath.sv =====
// ----------------------------------------------------------------------------
// dlr_datapath
// weight, bias and input stores, mac pipeline, relu and output register
// ----------------------------------------------------------------------------
module dlr_datapath import dlr_pkg::*; #(
  parameter int unsigned MAX_INPUTS  = 16,
  parameter int unsigned MAX_OUTPUTS = 16,
  localparam int unsigned IW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int unsigned OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
  localparam int unsigned WD    = MAX_INPUTS * MAX_OUTPUTS,
  localparam int unsigned AW    = (WD > 1) ? $clog2(WD) : 1,
  localparam int unsigned ACC_W = 2 * VALUE_W + $clog2(MAX_INPUTS) + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [OW-1:0]      r_i,
  input  logic [IW-1:0]      c_i,
  input  logic [IDX_W-1:0]   row_i,
  input  logic [IDX_W-1:0]   col_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [IDX_W-1:0]   neuron_o,
  output logic [ACT_W-1:0]   activation_o,
  output logic               last_result_o
);

  logic [AW-1:0]      w_waddr, w_raddr;
  logic [VALUE_W-1:0] w_rdata, b_rdata, x_rdata;
  logic [MAX_INPUTS-1:0] x_vld_q;

  logic               s1_vld_q, s1_first_q, s1_last_q, s1_xvld_q;
  logic               s2_vld_q, s2_first_q, s2_last_q;
  logic signed [2*VALUE_W-1:0] prod_q;
  logic [VALUE_W-1:0] bias_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc_base;
  logic               acc_done_q;
  logic [VALUE_W-1:0] x_op;

  logic               out_vld_q;
  logic [IDX_W-1:0]   neuron_q;
  logic [ACT_W-1:0]   act_q, act_d;
  logic               last_q;

  assign w_waddr = AW'(32'(row_i) * MAX_INPUTS + 32'(col_i));
  assign w_raddr = AW'(32'(r_i) * MAX_INPUTS + 32'(c_i));

  dlr_ram #(.WIDTH(VALUE_W), .DEPTH(WD)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.w_we),
    .waddr_i (w_waddr),
    .wdata_i (value_i),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  dlr_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.b_we),
    .waddr_i (OW'(row_i)),
    .wdata_i (value_i),
    .raddr_i (r_i),
    .rdata_o (b_rdata)
  );

  dlr_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_INPUTS)) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.x_we),
    .waddr_i (IW'(col_i)),
    .wdata_i (value_i),
    .raddr_i (c_i),
    .rdata_o (x_rdata)
  );

  // an input entry not written since the last vector reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= '0;
    end else if (cmd_i.clear_x) begin
      x_vld_q <= '0;
    end else if (cmd_i.x_we) begin
      x_vld_q[IW'(col_i)] <= 1'b1;
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.issue;
      s2_vld_q   <= s1_vld_q;
      acc_done_q <= s2_vld_q && s2_last_q;
    end
  end

  assign x_op = s1_xvld_q ? x_rdata : '0;

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.lastc;
    s1_xvld_q  <= x_vld_q[c_i];
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    prod_q     <= $signed(w_rdata) * $signed(x_op);
    bias_q     <= b_rdata;
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // bias aligned to q16.16 seeds the sum of each row
  assign acc_base = s2_first_q ? ACC_W'(signed'({bias_q, 8'h00})) : acc_q;
  assign acc_d    = acc_base + ACC_W'(prod_q);

  always_comb begin
    if (acc_q[ACC_W-1] || (acc_q == '0)) begin
      act_d = '0;
    end else if (|acc_q[ACC_W-2:ACT_W+8]) begin
      act_d = ACT_MAX;
    end else begin
      act_d = acc_q[ACT_W+7:8];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      neuron_q <= IDX_W'(r_i);
      act_q    <= act_d;
      last_q   <= cmd_i.last_row;
    end
  end

  assign sts_o.acc_done = acc_done_q;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o   = out_vld_q;
  assign neuron_o      = neuron_q;
  assign activation_o  = act_q;
  assign last_result_o = last_q;

endmodule

// ===== src/dense_layer_relu_top.sv =====
// ----------------------------------------------------------------------------
// dense_layer_relu_top
// fully connected layer with relu, q8.8 in and out
// ----------------------------------------------------------------------------
// input channel: one item per transfer. op 0 stores weight[row][col], op 1
//   stores bias[row], op 2 stores input element x[col]. these can follow
//   back to back while the block is idle.
// an op 2 item with last_element set starts the layer: for each neuron the
//   single weight ram port and one multiplier run one mac per cycle, and a
//   neuron passes through mac issue, ram read, multiply, accumulate and
//   result load. no input is taken meanwhile.
// output channel: one transfer per neuron, neuron 0 first, last_result set on
//   the final one. a stalled receiver holds the result in the output register
//   and halts the sequencer once the next neuron's sum is ready; after the
//   final result the block accepts input again while that result still waits.
// input elements are cleared after each vector; weights and biases persist.
// configuration channel: index 0 inputs_in_use, index 1 outputs_in_use,
//   always ready, written while the block is idle.
// reset: counts go to 16, the input store reads as zero, weight and bias
//   stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module dense_layer_relu_top import dlr_pkg::*; #(
  parameter int unsigned MAX_INPUTS  = 16,
  parameter int unsigned MAX_OUTPUTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IDX_W-1:0]     row_i,
  input  logic [IDX_W-1:0]     col_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic                 last_element_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_W-1:0]     neuron_o,
  output logic [ACT_W-1:0]     activation_o,
  output logic                 last_result_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [OW-1:0] r_idx;
  logic [IW-1:0] c_idx;

  // registers are plain flops, a write never waits
  assign cfg_ready_o = 1'b1;

  // sequencer: decodes items, walks neurons and elements
  dlr_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .last_element_i (last_element_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .r_o            (r_idx),
    .c_o            (c_idx)
  );

  // stores, mac pipeline, relu and the output register
  dlr_datapath #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .r_i           (r_idx),
    .c_i           (c_idx),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_i       (value_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .neuron_o      (neuron_o),
    .activation_o  (activation_o),
    .last_result_o (last_result_o)
  );

endmodule

// ===== src/dlr_checker.sv =====
// ----------------------------------------------------------------------------
// dlr_checker
// port level checks of the dense layer, bound to the top level
// ----------------------------------------------------------------------------
module dlr_checker import dlr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [OP_W-1:0]      op_i,
  input logic                 last_element_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [IDX_W-1:0]     neuron_o,
  input logic [ACT_W-1:0]     activation_o,
  input logic                 last_result_o
);

  logic in_xfer, out_xfer, trigger;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign trigger  = in_xfer && (op_i == OP_INPUT) && last_element_i;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(neuron_o)
      && $stable(activation_o) && $stable(last_result_o))
    else $error("stalled result changed");

  // a vector start blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trigger |=> !in_ready_o)
    else $error("input taken right after vector start");

  // store writes keep the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !trigger |=> in_ready_o)
    else $error("ready dropped after a store write");

  // more results of the vector follow, so input stays blocked unless the
  // final result was loaded at that same edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_result_o |=> !in_ready_o || (out_valid_o && last_result_o))
    else $error("input taken in the middle of a vector");

  // results only while no input is being taken, except the final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_ready_o |-> last_result_o)
    else $error("non-final result while idle");

endmodule

bind dense_layer_relu_top dlr_checker u_dlr_checker (.*);

// ===== tb/sv/dense_layer_relu_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_relu_top_tb
// self-checking bench for the dense layer with relu
// ----------------------------------------------------------------------------
// a queue of pending transfers (input items, register writes and sender
// pauses) is filled once at time zero and played out by a clocked driver.
// a clocked monitor keeps its own copy of the weight, bias and input stores,
// predicts the activations of every vector when the last element goes in,
// and checks each result transfer field by field against the oldest one due.
// the run preloads every weight and bias, walks a directed set of corner
// items, then goes through several register settings with random traffic.
// ----------------------------------------------------------------------------
module dense_layer_relu_top_tb;
  import dlr_pkg::*;

  localparam int unsigned MAX_INPUTS  = 16;
  localparam int unsigned MAX_OUTPUTS = 16;

  // op code the block does not define, must be dropped
  localparam logic [OP_W-1:0]      OP_UNUSED      = 2'd3;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd15;

  localparam int unsigned SETTLE_CYCLES  = 24;    // quiet time before a register write
  localparam int unsigned TAIL_CYCLES    = 400;   // quiet tail after the last result
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int unsigned HOLDOFF_CYCLES = 500;   // long receiver stall
  localparam int unsigned IDLE_PCT       = 27;
  localparam int unsigned CALM_FROM      = 800;   // window with no random idling on either side
  localparam int unsigned CALM_TO        = 1800;
  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum logic [1:0] {
    ENT_ITEM,
    ENT_CFG,
    ENT_DRAIN
  } entry_kind_e;

  typedef struct {
    entry_kind_e           kind;
    logic [OP_W-1:0]       op;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic [VALUE_W-1:0]    value;
    logic                  last_el;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_data;
  } stim_t;

  typedef struct {
    logic [IDX_W-1:0] neuron;
    logic [ACT_W-1:0] act;
    logic             last_res;
  } activ_t;

  // dut ports, all inputs known from time zero
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      op_i           = '0;
  logic [IDX_W-1:0]     row_i          = '0;
  logic [IDX_W-1:0]     col_i          = '0;
  logic [VALUE_W-1:0]   value_i        = '0;
  logic                 last_element_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [IDX_W-1:0]     neuron_o;
  logic [ACT_W-1:0]     activation_o;
  logic                 last_result_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i     = '0;

  // stimulus and expectations
  stim_t  items_to_send [$];
  activ_t activations_due [$];

  // predictor state
  logic [VALUE_W-1:0] w_mem [MAX_OUTPUTS*MAX_INPUTS];
  logic [VALUE_W-1:0] b_mem [MAX_OUTPUTS];
  logic [VALUE_W-1:0] x_mem [MAX_INPUTS];
  logic [CFG_W-1:0]   in_count  = CFG_RESET;
  logic [CFG_W-1:0]   out_count = CFG_RESET;

  // handshake flags from the monitor to the driver
  logic in_accepted  = 1'b0;
  logic cfg_accepted = 1'b0;

  // bookkeeping
  int unsigned cycle_cnt    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_run     = 0;
  int unsigned items_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned sat_cnt      = 0;
  int unsigned zero_cnt     = 0;
  int unsigned error_cnt    = 0;
  int unsigned holdoff_left  = 0;
  int unsigned holdoffs_done = 0;

  logic calm_window;
  assign calm_window = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  dense_layer_relu_top #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .value_i        (value_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .neuron_o       (neuron_o),
    .activation_o   (activation_o),
    .last_result_o  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // a count of 0 acts as 1, anything past the store acts as its size
  function automatic int unsigned clamp_count(logic [CFG_W-1:0] count, int unsigned lim);
    if (count == 0) return 1;
    if (32'(count) > lim) return lim;
    return 32'(count);
  endfunction

  // mix of extremes, small values that keep sums in range, and full range
  function automatic logic [VALUE_W-1:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8)  return 16'h7fff;
    if (sel < 16) return 16'h8000;
    if (sel < 22) return 16'h0000;
    if (sel < 70) return VALUE_W'($urandom_range(0, 1023) - 512);
    return VALUE_W'($urandom_range(0, 65535));
  endfunction

  function automatic void queue_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                     logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value,
                                     logic last_el);
    stim_t s;
    s = '{kind: ENT_ITEM, op: op, row: row, col: col, value: value, last_el: last_el,
          cfg_idx: '0, cfg_data: '0};
    items_to_send.push_back(s);
  endfunction

  function automatic void queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_t s;
    s = '{kind: ENT_CFG, op: '0, row: '0, col: '0, value: '0, last_el: 1'b0,
          cfg_idx: idx, cfg_data: data};
    items_to_send.push_back(s);
  endfunction

  // sender holds back until every due activation has come out
  function automatic void queue_drain();
    stim_t s;
    s = '{kind: ENT_DRAIN, op: '0, row: '0, col: '0, value: '0, last_el: 1'b0,
          cfg_idx: '0, cfg_data: '0};
    items_to_send.push_back(s);
  endfunction

  function automatic void note_mismatch(string msg);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // predictor: applies one accepted item to the stores and, on the last
  // element of a vector, works out the activation of every neuron in use
  function automatic void predict_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                       logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value,
                                       logic last_el);
    int unsigned n_in;
    int unsigned n_out;
    longint      acc;
    activ_t      res;
    case (op)
      OP_WEIGHT: w_mem[{row, col}] = value;
      OP_BIAS:   b_mem[row] = value;
      OP_INPUT: begin
        x_mem[col] = value;
        if (last_el) begin
          n_in  = clamp_count(in_count, MAX_INPUTS);
          n_out = clamp_count(out_count, MAX_OUTPUTS);
          for (int r = 0; r < n_out; r++) begin
            // q16.16 products, bias lifted to q16.16
            acc = 0;
            for (int c = 0; c < n_in; c++) begin
              acc += longint'($signed(w_mem[r*MAX_INPUTS + c])) *
                     longint'($signed(x_mem[c]));
            end
            acc += longint'($signed(b_mem[r])) * 256;
            res.neuron   = IDX_W'(r);
            res.last_res = (r + 1 == n_out);
            if (acc <= 0) begin
              res.act = '0;
            end else begin
              acc = acc / 256;
              res.act = (acc > 32767) ? ACT_MAX : acc[ACT_W-1:0];
            end
            activations_due.push_back(res);
          end
          for (int c = 0; c < MAX_INPUTS; c++) x_mem[c] = '0;
        end
      end
      default: ;  // unused op, dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents the next queued transfer at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic  nx_valid;
    logic  nx_cfg;
    stim_t head;
    if (rst_ni) begin
      nx_valid = in_valid_i && !in_accepted;
      nx_cfg   = cfg_valid_i && !cfg_accepted;
      if (!nx_valid && !nx_cfg && items_to_send.size() > 0) begin
        head = items_to_send[0];
        case (head.kind)
          ENT_ITEM: begin
            if (calm_window || $urandom_range(0, 99) >= IDLE_PCT) begin
              op_i           <= head.op;
              row_i          <= head.row;
              col_i          <= head.col;
              value_i        <= head.value;
              last_element_i <= head.last_el;
              nx_valid = 1'b1;
              void'(items_to_send.pop_front());
            end
          end
          ENT_CFG: begin
            // registers only change once the block has gone quiet
            if (activations_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              cfg_index_i <= head.cfg_idx;
              cfg_data_i  <= head.cfg_data;
              nx_cfg = 1'b1;
              void'(items_to_send.pop_front());
            end
          end
          default: begin
            if (activations_due.size() == 0) void'(items_to_send.pop_front());
          end
        endcase
      end
      in_valid_i  <= nx_valid;
      cfg_valid_i <= nx_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure plus two long hold-offs
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic rdy;
    if (rst_ni) begin
      if (holdoff_left > 0) begin
        holdoff_left--;
        rdy = 1'b0;
      end else if (out_valid_o &&
                   ((holdoffs_done == 0 && results_seen >= 20) ||
                    (holdoffs_done == 1 && results_seen >= 150))) begin
        // sender keeps offering items meanwhile, so the block backs up
        holdoff_left = HOLDOFF_CYCLES;
        holdoffs_done++;
        rdy = 1'b0;
      end else begin
        rdy = calm_window || ($urandom_range(0, 99) >= IDLE_PCT);
      end
      out_ready_i <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples every transfer at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    activ_t want;
    if (!rst_ni) begin
      in_accepted  <= 1'b0;
      cfg_accepted <= 1'b0;
    end else begin
      cycle_cnt++;
      in_accepted  <= in_valid_i && in_ready_o;
      cfg_accepted <= cfg_valid_i && cfg_ready_o;

      // results first: a transfer out always belongs to an older vector
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (activation_o == ACT_MAX) sat_cnt++;
        if (activation_o == '0) zero_cnt++;
        if (activations_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result neuron %0d act %0d last %0d",
                                  neuron_o, activation_o, last_result_o));
        end else begin
          want = activations_due.pop_front();
          if (neuron_o !== want.neuron || activation_o !== want.act ||
              last_result_o !== want.last_res) begin
            note_mismatch($sformatf(
              "result %0d exp neuron %0d act %0d last %0d, got neuron %0d act %0d last %0d",
              results_seen, want.neuron, want.act, want.last_res,
              neuron_o, activation_o, last_result_o));
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        items_taken++;
        predict_item(op_i, row_i, col_i, value_i, last_element_i);
      end

      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          CFG_IDX_INPUTS:  in_count  = cfg_data_i;
          CFG_IDX_OUTPUTS: out_count = cfg_data_i;
          default: ;
        endcase
      end

      // quiet time counts from the last transfer once nothing is due
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          activations_due.size() != 0) begin
        quiet_cycles = 0;
      end else if (quiet_cycles < SETTLE_CYCLES) begin
        quiet_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends a run that stops moving
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still due",
                 idle_run, activations_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] phase_in    [NUM_PHASES];
    logic [CFG_W-1:0] phase_out   [NUM_PHASES];
    int unsigned      phase_quota [NUM_PHASES];
    int unsigned      n_eff;
    int unsigned      sent;
    int unsigned      pick;
    int unsigned      k;
    logic [IDX_W-1:0] col;

    for (int c = 0; c < MAX_INPUTS; c++) x_mem[c] = '0;

    // every weight and bias gets a value before the first vector reads it;
    // last_element on these writes must be ignored
    for (int r = 0; r < MAX_OUTPUTS; r++) begin
      for (int c = 0; c < MAX_INPUTS; c++) begin
        queue_item(OP_WEIGHT, IDX_W'(r), IDX_W'(c), rand_value(), 1'($urandom_range(0, 1)));
      end
      queue_item(OP_BIAS, IDX_W'(r), IDX_W'($urandom_range(0, 15)), rand_value(),
                 1'($urandom_range(0, 1)));
    end

    // directed corners at the reset setting of 16 x 16
    queue_item(OP_UNUSED, 4'hf, 4'hf, 16'hffff, 1'b1);   // dropped, no results
    queue_item(OP_WEIGHT, 4'h0, 4'h0, 16'h7fff, 1'b1);   // no computation
    queue_item(OP_WEIGHT, 4'h0, 4'h1, 16'h7fff, 1'b0);
    queue_item(OP_BIAS,   4'h0, 4'h0, 16'h7fff, 1'b1);   // no computation
    queue_item(OP_WEIGHT, 4'h1, 4'h0, 16'h8000, 1'b0);
    queue_item(OP_WEIGHT, 4'h1, 4'h1, 16'h8000, 1'b0);
    queue_item(OP_BIAS,   4'h1, 4'h0, 16'h8000, 1'b0);
    queue_item(OP_INPUT,  4'h0, 4'h0, 16'h7fff, 1'b0);
    queue_item(OP_INPUT,  4'h0, 4'h1, 16'h7fff, 1'b0);
    queue_item(OP_INPUT,  4'h0, 4'hf, 16'h8000, 1'b0);
    queue_item(OP_INPUT,  4'hf, 4'h2, 16'h0000, 1'b1);   // neuron 0 saturates, 1 clamps
    queue_drain();
    queue_item(OP_INPUT,  4'h0, 4'h9, 16'h0000, 1'b1);   // cleared store, bias only
    queue_item(OP_INPUT,  4'h0, 4'h3, 16'h0080, 1'b0);
    queue_item(OP_INPUT,  4'h0, 4'h3, 16'h0100, 1'b0);   // overwrite of one element
    queue_item(OP_BIAS,   4'hf, 4'h0, 16'h0000, 1'b0);
    queue_item(OP_WEIGHT, 4'hf, 4'hf, 16'hffff, 1'b0);
    queue_item(OP_INPUT,  4'h0, 4'hf, 16'hffff, 1'b1);

    // register settings, extremes and out-of-range counts among them
    phase_in    = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd1,  5'd17, 5'd2, 5'd2};
    phase_out   = '{5'd1, 5'd0, 5'd31, 5'd8, 5'd1,  5'd16, 5'd3,  5'd2, 5'd2};
    phase_quota = '{15,   10,   10,    15,   10,    15,    15,    15,   15};
    for (int p = 7; p < NUM_PHASES; p++) begin
      phase_in[p]  = CFG_W'($urandom_range(1, 6));
      phase_out[p] = CFG_W'($urandom_range(1, 6));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      queue_cfg(CFG_IDX_INPUTS, phase_in[p]);
      queue_cfg(CFG_IDX_OUTPUTS, phase_out[p]);
      if (p == 3) queue_cfg(CFG_IDX_UNUSED, 5'd3);   // no register there
      n_eff = clamp_count(phase_in[p], MAX_INPUTS);
      sent  = 0;
      while (sent < phase_quota[p]) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // well-formed vector: elements mostly inside the used range
          k = $urandom_range(0, n_eff);
          for (int e = 0; e < k; e++) begin
            col = ($urandom_range(0, 9) < 8) ? IDX_W'($urandom_range(0, n_eff - 1))
                                              : IDX_W'($urandom_range(0, 15));
            queue_item(OP_INPUT, IDX_W'($urandom_range(0, 15)), col, rand_value(), 1'b0);
          end
          queue_item(OP_INPUT, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                     rand_value(), 1'b1);
          sent += k + 1;
        end else if (pick < 75) begin
          queue_item(OP_WEIGHT, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                     rand_value(), 1'($urandom_range(0, 1)));
          sent++;
        end else if (pick < 86) begin
          queue_item(OP_BIAS, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                     rand_value(), 1'($urandom_range(0, 1)));
          sent++;
        end else if (pick < 92) begin
          queue_item(OP_UNUSED, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                     VALUE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end else if (pick < 98) begin
          // stray element, left in the store for a later vector
          queue_item(OP_INPUT, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                     rand_value(), 1'b0);
          sent++;
        end else begin
          queue_drain();
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // everything handed over, then everything back, then a quiet tail
    while (items_to_send.size() != 0 || in_valid_i || cfg_valid_i) @(negedge clk_i);
    while (activations_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (activations_due.size() != 0) note_mismatch("results still due at the end");

    $display("run covered %0d input transfers, %0d register writes, %0d checked results",
             items_taken, cfg_writes, results_seen);
    $display("of those results %0d saturated and %0d clamped to zero, %0d hold-offs",
             sat_cnt, zero_cnt, holdoffs_done);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
